@@ rtl/bdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with member search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  // actions
  localparam logic [1:0] ACT_PUSH     = 2'd0;
  localparam logic [1:0] ACT_POP_HEAD = 2'd1;
  localparam logic [1:0] ACT_POP_TAIL = 2'd2;
  localparam logic [1:0] ACT_LOOKUP   = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STS_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] head_value;
    logic signed [VAL_W-1:0] tail_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
    logic [1:0]              status;
  } rsp_t;

  // per-cell control: shift takes the right-hand neighbour, load takes new data
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/bdq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain; shifts from its neighbour or loads.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; (
  input  wire logic                    clk,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic signed [VAL_W-1:0] nbr_value,
  input  wire logic signed [VAL_W-1:0] load_value,
  output logic signed [VAL_W-1:0]      value
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= nbr_value;
    end else if (ctrl.load) begin
      value <= load_value;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bounded_deque_with_member_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_member_search
// Bounded deque of signed 32-bit values held in a rotating chain of cells,
// with push at tail, pop at either end and a membership lookup.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  request   in         start & !busy at clk edge  request (req_t)
//  result    out        done high for one cycle    result  (rsp_t)
//
//  Push and both pops go from acceptance through ST_REPORT to done; a lookup
//  first passes ST_SCAN, where the chain rotates once past the compare at cell 0.
//  busy is high from acceptance until the cycle done is raised, so a new
//  request may be accepted while the previous result is on the ports.
//  Synchronous active-high reset empties the deque; cell contents are not
//  cleared and are only ever read at occupied positions.
//  The receiver cannot stall: each result is presented exactly once.
//
module bounded_deque_with_member_search import bdq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output logic      done,
  output rsp_t      result
);

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0]              state;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        step;
  logic signed [VAL_W-1:0] key;
  logic                    found_acc;
  logic [1:0]              status_r;

  logic signed [VAL_W-1:0] cells [DEPTH];
  cell_ctrl_t              ctrl   [DEPTH];

  logic accept;
  logic is_full;
  logic is_empty_now;
  logic do_shift;
  logic do_load;
  logic [IDX_W-1:0] tail_idx;

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign is_full      = (count == CNT_W'(DEPTH));
  assign is_empty_now = (count == '0);

  // Rotation: one step per pop-head on a non-empty deque, DEPTH steps for a
  // full lookup pass, which brings the chain back to its original order.
  assign do_shift = (accept && request.action == ACT_POP_HEAD && !is_empty_now) ||
                    (state == ST_SCAN);
  assign do_load  = accept && request.action == ACT_PUSH && !is_full;
  assign tail_idx = IDX_W'(count - CNT_W'(1));

  // cell chain: head sits in cell 0, cell i takes cell i+1 on a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].shift = do_shift;
    assign ctrl[i].load  = do_load && (count[IDX_W-1:0] == IDX_W'(i));

    bdq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .nbr_value  (cells[(i + 1) % DEPTH]),
      .load_value (request.item_value),
      .value      (cells[i])
    );
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key       <= request.item_value;
            found_acc <= 1'b0;
            step      <= '0;
            status_r  <= STS_OK;
            state     <= ST_REPORT;
            case (request.action)
              ACT_PUSH: begin
                if (is_full) status_r <= STS_PUSH_FULL;
                else         count    <= count + CNT_W'(1);
              end
              ACT_POP_HEAD, ACT_POP_TAIL: begin
                if (is_empty_now) status_r <= STS_POP_EMPTY;
                else              count    <= count - CNT_W'(1);
              end
              default: begin
                state <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // only occupied positions take part in the compare
          if (cells[0] == key && CNT_W'(step) < count) found_acc <= 1'b1;
          step <= step + IDX_W'(1);
          if (step == IDX_W'(DEPTH - 1)) state <= ST_REPORT;
        end
        ST_REPORT: begin
          result.found       <= found_acc;
          result.head_value  <= is_empty_now ? '0 : cells[0];
          result.tail_value  <= is_empty_now ? '0 : cells[tail_idx];
          result.entry_count <= count;
          result.is_empty    <= is_empty_now;
          result.status      <= status_r;
          done               <= 1'b1;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_REPORT)
    else $error("done raised outside report");

  a_scan_holds_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |=> $stable(count))
    else $error("count changed during lookup");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && request.action == ACT_PUSH && !is_full |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow count");

  a_scan_restores: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && step == IDX_W'(DEPTH - 1) |=> state == ST_REPORT)
    else $error("lookup pass did not end");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded deque with member search: a directed
// table followed by random requests, each result checked against a typed
// expectation or a shadow copy of the deque kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  import bdq_pkg::*;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int STALL_LIMIT     = 2000;  // cycles with no request and no result
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // one line of the directed table; reps > 1 repeats the request with the
  // value stepped by one each time
  typedef struct {
    req_t req;
    int   reps;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic start   = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  // typed expectation travelling alongside the request being offered
  bit   row_typed = 1'b0;
  rsp_t row_want  = '0;

  // shadow of the deque contents
  logic signed [VAL_W-1:0] mirror_cells [DEPTH];
  int mirror_head  = 0;
  int mirror_count = 0;

  rsp_t      awaited_outcomes [$];
  plan_row_t plan [$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  bit        calm           = 1'b0;  // suppresses sender gaps

  bounded_deque_with_member_search i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one request to the shadow deque and returns the result it must
  // produce. Pops and lookups leave the cells untouched; only occupied
  // positions are ever compared.
  function automatic rsp_t predict_outcome(req_t r);
    rsp_t o;
    int   k;
    o = '0;
    case (r.action)
      ACT_PUSH: begin
        if (mirror_count == DEPTH) begin
          o.status = STS_PUSH_FULL;
        end else begin
          mirror_cells[IDX_W'((mirror_head + mirror_count) % DEPTH)] = r.item_value;
          mirror_count++;
        end
      end
      ACT_POP_HEAD: begin
        if (mirror_count == 0) begin
          o.status = STS_POP_EMPTY;
        end else begin
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      ACT_POP_TAIL: begin
        if (mirror_count == 0) begin
          o.status = STS_POP_EMPTY;
        end else begin
          mirror_count--;
        end
      end
      default: begin
        for (k = 0; k < mirror_count; k++) begin
          if (mirror_cells[IDX_W'((mirror_head + k) % DEPTH)] == r.item_value)
            o.found = 1'b1;
        end
      end
    endcase
    if (mirror_count > 0) begin
      o.head_value = mirror_cells[IDX_W'(mirror_head)];
      o.tail_value = mirror_cells[IDX_W'((mirror_head + mirror_count - 1) % DEPTH)];
    end
    o.entry_count = CNT_W'(mirror_count);
    o.is_empty    = (mirror_count == 0);
    return o;
  endfunction

  function automatic rsp_t outcome(int f, logic signed [VAL_W-1:0] h,
                                   logic signed [VAL_W-1:0] t, int c, int e,
                                   logic [1:0] s);
    rsp_t o;
    o.found       = 1'(f);
    o.head_value  = h;
    o.tail_value  = t;
    o.entry_count = CNT_W'(c);
    o.is_empty    = 1'(e);
    o.status      = s;
    return o;
  endfunction

  task automatic add_row(logic [1:0] act, logic signed [VAL_W-1:0] val, int reps,
                         bit typed, rsp_t want);
    plan_row_t row;
    row.req.action     = act;
    row.req.item_value = val;
    row.reps           = reps;
    row.typed          = typed;
    row.want           = want;
    plan.push_back(row);
  endtask

  task automatic flag_field(string fld, logic signed [63:0] want,
                            logic signed [63:0] seen);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, fld, want, seen);
  endtask

  // Offers one request. Random gaps go in first, with junk on the payload
  // so that nothing is taken without start; then start is held until the
  // block is seen not busy at a rising edge.
  task automatic send(req_t r, bit typed, rsp_t want);
    while (!calm && $urandom_range(0, 99) < 13) begin
      @(negedge clk);
      start   <= 1'b0;
      request <= '{action: 2'($urandom), item_value: $urandom};
    end
    @(negedge clk);
    start     <= 1'b1;
    request   <= r;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  // Result checker and request capture, both on the rising edge. A result
  // is compared before the request of the same edge is queued, so the
  // oldest expectation always meets the result first.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request outstanding, got %p", $time, result);
        end else begin
          want = awaited_outcomes.pop_front();
          if (result.found !== want.found)
            flag_field("found", 64'(want.found), 64'(result.found));
          if (result.head_value !== want.head_value)
            flag_field("head_value", 64'(want.head_value), 64'(result.head_value));
          if (result.tail_value !== want.tail_value)
            flag_field("tail_value", 64'(want.tail_value), 64'(result.tail_value));
          if (result.entry_count !== want.entry_count)
            flag_field("entry_count", 64'(want.entry_count), 64'(result.entry_count));
          if (result.is_empty !== want.is_empty)
            flag_field("is_empty", 64'(want.is_empty), 64'(result.is_empty));
          if (result.status !== want.status)
            flag_field("status", 64'(want.status), 64'(result.status));
        end
      end
      if (start && !busy) begin
        // shadow always advances; typed rows override its answer
        want = predict_outcome(request);
        awaited_outcomes.push_back(row_typed ? row_want : want);
      end
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("** bounded_deque_with_member_search: FAILED **");
    $finish;
  end

  initial begin : stimulus
    plan_row_t               row;
    req_t                    r;
    int                      rep;
    int                      n;
    int                      push_cut;
    int                      sel;
    bit                      filling;
    logic signed [VAL_W-1:0] pool [8];

    // -- directed table ------------------------------------------------------
    // empty deque: both pops refused, lookup misses
    add_row(ACT_POP_HEAD, 0, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_POP_EMPTY));
    add_row(ACT_POP_TAIL, -1, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_POP_EMPTY));
    add_row(ACT_LOOKUP, 0, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_OK));
    // extremes at both ends
    add_row(ACT_PUSH, VAL_MIN, 1, 1'b1, outcome(0, VAL_MIN, VAL_MIN, 1, 0, STS_OK));
    add_row(ACT_PUSH, VAL_MAX, 1, 1'b1, outcome(0, VAL_MIN, VAL_MAX, 2, 0, STS_OK));
    add_row(ACT_LOOKUP, VAL_MAX, 1, 1'b1, outcome(1, VAL_MIN, VAL_MAX, 2, 0, STS_OK));
    add_row(ACT_LOOKUP, VAL_MIN, 1, 1'b1, outcome(1, VAL_MIN, VAL_MAX, 2, 0, STS_OK));
    add_row(ACT_LOOKUP, -1, 1, 1'b1, outcome(0, VAL_MIN, VAL_MAX, 2, 0, STS_OK));
    add_row(ACT_POP_HEAD, 0, 1, 1'b1, outcome(0, VAL_MAX, VAL_MAX, 1, 0, STS_OK));
    add_row(ACT_POP_TAIL, 0, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_OK));
    add_row(ACT_POP_TAIL, 0, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_POP_EMPTY));
    // stale cell still holds the old value but must not match when empty
    add_row(ACT_LOOKUP, VAL_MAX, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_OK));
    // fill across the sign boundary, then push on full is dropped
    add_row(ACT_PUSH, -8, DEPTH, 1'b0, '0);
    add_row(ACT_PUSH, 5, 1, 1'b1, outcome(0, -8, 7, DEPTH, 0, STS_PUSH_FULL));
    add_row(ACT_LOOKUP, 7, 1, 1'b1, outcome(1, -8, 7, DEPTH, 0, STS_OK));
    add_row(ACT_LOOKUP, 8, 1, 1'b1, outcome(0, -8, 7, DEPTH, 0, STS_OK));
    // move the head round the ring and refill so the tail wraps
    add_row(ACT_POP_HEAD, 0, 5, 1'b0, '0);
    add_row(ACT_PUSH, 100, 5, 1'b0, '0);
    add_row(ACT_LOOKUP, 104, 1, 1'b0, '0);
    add_row(ACT_LOOKUP, -8, 1, 1'b0, '0);
    add_row(ACT_PUSH, 0, 1, 1'b0, '0);
    add_row(ACT_POP_TAIL, 0, DEPTH, 1'b0, '0);
    add_row(ACT_POP_HEAD, 0, 1, 1'b1, outcome(0, 0, 0, 0, 1, STS_POP_EMPTY));
    add_row(ACT_PUSH, 32'sh5555_5555, 1, 1'b0, '0);
    add_row(ACT_PUSH, 32'shAAAA_AAAA, 1, 1'b0, '0);
    add_row(ACT_LOOKUP, 32'shAAAA_AAAA, 1, 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      for (rep = 0; rep < row.reps; rep++) begin
        r.action     = row.req.action;
        r.item_value = row.req.item_value + rep;
        send(r, row.typed, row.want);
      end
    end

    // -- random requests -----------------------------------------------------
    // Values mostly come from a small pool so lookups hit often; the mix
    // drifts between filling and draining so both the full and the empty
    // ends are reached repeatedly.
    foreach (pool[i]) pool[i] = $urandom;
    filling = 1'b1;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 400 && n < 700);
      if ($urandom_range(0, 39) == 0) filling = !filling;
      push_cut = filling ? 55 : 20;
      sel      = $urandom_range(0, 99);
      if (sel < push_cut) begin
        r.action = ACT_PUSH;
      end else if (sel < push_cut + 22) begin
        r.action = ACT_LOOKUP;
      end else if ($urandom_range(0, 1) == 0) begin
        r.action = ACT_POP_HEAD;
      end else begin
        r.action = ACT_POP_TAIL;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        r.item_value = pool[3'($urandom_range(0, 7))];
      end else if (sel == 6) begin
        sel = $urandom_range(0, 3);
        r.item_value = (sel == 0) ? VAL_MIN : (sel == 1) ? VAL_MAX : (sel == 2) ? 0 : -1;
      end else begin
        r.item_value = $urandom;
      end
      if ($urandom_range(0, 99) == 0) pool[3'($urandom_range(0, 7))] = $urandom;
      send(r, 1'b0, '0);
    end

    // -- wind down -----------------------------------------------------------
    @(negedge clk);
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** bounded_deque_with_member_search: PASSED **");
    end else begin
      $display("** bounded_deque_with_member_search: FAILED **");
    end
    $finish;
  end

endmodule
